// File: hdl/tlrq_pkg.sv
// Shared types, constants and helpers for the two-level task run queue.
package tlrq_pkg;

   localparam int ACTION_DEPTH = 16;
   localparam int WORKER_DEPTH = 32;

   localparam int ID_W   = 16;
   localparam int OP_W   = 3;
   localparam int STS_W  = 2;
   localparam int PEND_W = 6;
   localparam int CNT_W  = 8;

   localparam int AQ_AW = $clog2(ACTION_DEPTH);
   localparam int AQ_CW = $clog2(ACTION_DEPTH + 1);
   localparam int WQ_AW = $clog2(WORKER_DEPTH);
   localparam int WQ_CW = $clog2(WORKER_DEPTH + 1);
   localparam int WALK_CW = (AQ_CW > WQ_CW) ? AQ_CW : WQ_CW;
   localparam int SUM_W = (WALK_CW + 1 > PEND_W) ? WALK_CW + 1 : PEND_W;

   localparam logic [OP_W-1:0] OP_PUSH_ACT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_WRK = 3'd1;
   localparam logic [OP_W-1:0] OP_REM_ACT  = 3'd2;
   localparam logic [OP_W-1:0] OP_REM_WRK  = 3'd3;
   localparam logic [OP_W-1:0] OP_ACTIVATE = 3'd4;
   localparam logic [OP_W-1:0] OP_DISPATCH = 3'd5;

   localparam logic [STS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic [ID_W-1:0] task_id;
   } req_word_type;

   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic              dispatched;
      logic [ID_W-1:0]   run_id;
      logic              from_actions;
      logic [PEND_W-1:0] pending_total;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic select;
      logic sel_wq;
      logic walk_step;
      logic walk_end;
      logic push;
      logic pop_take;
      logic underflow;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            a_empty;
      logic            w_empty;
      logic            walk_done;
      logic            rsp_free;
   } sts_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_WALK,
      S_PUSH,
      S_POP_RD,
      S_POP_TAKE,
      S_DONE
   } state_type;

   // Circular index: base stays below depth and off is at most depth.
   function automatic int wrap_add(int base, int off, int depth);
      int s;
      s = base + off;
      if (s >= depth) s = s - depth;
      return s;
   endfunction

endpackage

// File: hdl/tlrq_ctrl.sv
// Sequencer that steps each request through decode, walk, push and pop.
module tlrq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tlrq_pkg::sts_type sts,
   output tlrq_pkg::cmd_type cmd
);
   import tlrq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.select = 1'b1;
            unique case (sts.opcode)
               OP_PUSH_ACT: begin
                  cmd.sel_wq = 1'b0;
                  state_in   = S_PUSH;
               end
               OP_PUSH_WRK: begin
                  cmd.sel_wq = 1'b1;
                  state_in   = S_PUSH;
               end
               OP_REM_ACT: begin
                  cmd.sel_wq = 1'b0;
                  state_in   = S_WALK;
               end
               OP_REM_WRK, OP_ACTIVATE: begin
                  cmd.sel_wq = 1'b1;
                  state_in   = S_WALK;
               end
               OP_DISPATCH: begin
                  priority if (!sts.a_empty) begin
                     cmd.sel_wq = 1'b0;
                     state_in   = S_POP_RD;
                  end else if (!sts.w_empty) begin
                     cmd.sel_wq = 1'b1;
                     state_in   = S_POP_RD;
                  end else begin
                     cmd.underflow = 1'b1;
                     state_in      = S_DONE;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_done) begin
               cmd.walk_end = 1'b1;
               state_in = (sts.opcode == OP_ACTIVATE) ? S_PUSH : S_DONE;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_DONE;
         end
         S_POP_RD: begin
            // head entry read is in flight
            state_in = S_POP_TAKE;
         end
         S_POP_TAKE: begin
            cmd.pop_take = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/tlrq_dpath.sv
// Queue storage, pointers, compaction walk and response register.
module tlrq_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  tlrq_pkg::req_word_type req_word,
   input  tlrq_pkg::cmd_type      cmd,
   output tlrq_pkg::sts_type      sts,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output tlrq_pkg::rsp_word_type rsp_word
);
   import tlrq_pkg::*;

   logic [ID_W-1:0] aq_mem_ff [ACTION_DEPTH];
   logic [ID_W-1:0] wq_mem_ff [WORKER_DEPTH];
   logic [ID_W-1:0] aq_rdata_ff, wq_rdata_ff;

   logic [OP_W-1:0]    op_ff, op_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic               sel_ff, sel_in;
   logic [AQ_AW-1:0]   aq_head_ff, aq_head_in;
   logic [AQ_CW-1:0]   aq_count_ff, aq_count_in;
   logic [WQ_AW-1:0]   wq_head_ff, wq_head_in;
   logic [WQ_CW-1:0]   wq_count_ff, wq_count_in;
   logic [WALK_CW-1:0] walk_r_ff, walk_r_in;
   logic [WALK_CW-1:0] walk_w_ff, walk_w_in;
   logic               pend_ff, pend_in;
   logic [STS_W-1:0]   status_ff, status_in;
   logic               disp_ff, disp_in;
   logic [ID_W-1:0]    run_ff, run_in;
   logic               from_ff, from_in;
   logic [CNT_W-1:0]   aq_ovf_ff, aq_ovf_in;
   logic [CNT_W-1:0]   wq_ovf_ff, wq_ovf_in;
   logic [CNT_W-1:0]   udf_ff, udf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic [WALK_CW-1:0] cur_count;
   logic [ID_W-1:0]    cur_rdata;
   logic               full;
   logic               keep;
   logic               wr_en;
   logic [WALK_CW-1:0] wr_off;
   logic [ID_W-1:0]    wr_data;
   logic [AQ_AW-1:0]   aq_raddr, aq_waddr;
   logic [WQ_AW-1:0]   wq_raddr, wq_waddr;
   logic [SUM_W-1:0]   pend_sum;

   assign cur_count = sel_ff ? WALK_CW'(wq_count_ff) : WALK_CW'(aq_count_ff);
   assign cur_rdata = sel_ff ? wq_rdata_ff : aq_rdata_ff;
   assign full      = sel_ff ? (cur_count == WALK_CW'(WORKER_DEPTH))
                             : (cur_count == WALK_CW'(ACTION_DEPTH));
   assign keep      = pend_ff && (cur_rdata != id_ff);
   assign wr_en     = (cmd.walk_step && keep) || (cmd.push && !full);
   assign wr_off    = cmd.push ? cur_count : walk_w_ff;
   assign wr_data   = cmd.push ? id_ff : cur_rdata;

   assign aq_raddr = AQ_AW'(wrap_add(int'(aq_head_ff), int'(walk_r_ff), ACTION_DEPTH));
   assign wq_raddr = WQ_AW'(wrap_add(int'(wq_head_ff), int'(walk_r_ff), WORKER_DEPTH));
   assign aq_waddr = AQ_AW'(wrap_add(int'(aq_head_ff), int'(wr_off), ACTION_DEPTH));
   assign wq_waddr = WQ_AW'(wrap_add(int'(wq_head_ff), int'(wr_off), WORKER_DEPTH));

   assign pend_sum = SUM_W'(aq_count_ff) + SUM_W'(wq_count_ff);

   always_ff @(posedge clock) begin
      if (wr_en && !sel_ff) aq_mem_ff[aq_waddr] <= wr_data;
      aq_rdata_ff <= aq_mem_ff[aq_raddr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && sel_ff) wq_mem_ff[wq_waddr] <= wr_data;
      wq_rdata_ff <= wq_mem_ff[wq_raddr];
   end

   always_comb begin
      op_in        = op_ff;
      id_in        = id_ff;
      sel_in       = sel_ff;
      aq_head_in   = aq_head_ff;
      aq_count_in  = aq_count_ff;
      wq_head_in   = wq_head_ff;
      wq_count_in  = wq_count_ff;
      walk_r_in    = walk_r_ff;
      walk_w_in    = walk_w_ff;
      pend_in      = pend_ff;
      status_in    = status_ff;
      disp_in      = disp_ff;
      run_in       = run_ff;
      from_in      = from_ff;
      aq_ovf_in    = aq_ovf_ff;
      wq_ovf_in    = wq_ovf_ff;
      udf_in       = udf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      if (cmd.load) begin
         op_in     = req_word.opcode;
         id_in     = req_word.task_id;
         walk_r_in = '0;
         walk_w_in = '0;
         pend_in   = 1'b0;
         status_in = ST_OK;
         disp_in   = 1'b0;
         run_in    = '0;
         from_in   = 1'b0;
      end
      if (cmd.select) sel_in = cmd.sel_wq;

      // Read entry r, compare its registered read data in the next cycle and pack survivors at w.
      if (cmd.walk_step) begin
         if (keep) walk_w_in = walk_w_ff + 1'b1;
         pend_in = (walk_r_ff != cur_count);
         if (walk_r_ff != cur_count) walk_r_in = walk_r_ff + 1'b1;
      end
      if (cmd.walk_end) begin
         if (sel_ff) wq_count_in = WQ_CW'(walk_w_ff);
         else        aq_count_in = AQ_CW'(walk_w_ff);
      end

      if (cmd.push) begin
         if (full) begin
            status_in = ST_FULL;
            if (sel_ff) wq_ovf_in = wq_ovf_ff + 1'b1;
            else        aq_ovf_in = aq_ovf_ff + 1'b1;
         end else if (sel_ff) begin
            wq_count_in = wq_count_ff + 1'b1;
         end else begin
            aq_count_in = aq_count_ff + 1'b1;
         end
      end

      if (cmd.pop_take) begin
         run_in  = cur_rdata;
         disp_in = 1'b1;
         from_in = !sel_ff;
         if (sel_ff) begin
            wq_head_in  = WQ_AW'(wrap_add(int'(wq_head_ff), 1, WORKER_DEPTH));
            wq_count_in = wq_count_ff - 1'b1;
         end else begin
            aq_head_in  = AQ_AW'(wrap_add(int'(aq_head_ff), 1, ACTION_DEPTH));
            aq_count_in = aq_count_ff - 1'b1;
         end
      end

      if (cmd.underflow) begin
         status_in = ST_EMPTY;
         udf_in    = udf_ff + 1'b1;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.status        = status_ff;
         rsp_word_in.dispatched    = disp_ff;
         rsp_word_in.run_id        = run_ff;
         rsp_word_in.from_actions  = from_ff;
         rsp_word_in.pending_total = pend_sum[PEND_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= 1'b0;
         aq_head_ff   <= '0;
         aq_count_ff  <= '0;
         wq_head_ff   <= '0;
         wq_count_ff  <= '0;
         walk_r_ff    <= '0;
         walk_w_ff    <= '0;
         pend_ff      <= 1'b0;
         aq_ovf_ff    <= '0;
         wq_ovf_ff    <= '0;
         udf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sel_ff       <= sel_in;
         aq_head_ff   <= aq_head_in;
         aq_count_ff  <= aq_count_in;
         wq_head_ff   <= wq_head_in;
         wq_count_ff  <= wq_count_in;
         walk_r_ff    <= walk_r_in;
         walk_w_ff    <= walk_w_in;
         pend_ff      <= pend_in;
         aq_ovf_ff    <= aq_ovf_in;
         wq_ovf_ff    <= wq_ovf_in;
         udf_ff       <= udf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      status_ff   <= status_in;
      disp_ff     <= disp_in;
      run_ff      <= run_in;
      from_ff     <= from_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign sts.opcode    = op_ff;
   assign sts.a_empty   = (aq_count_ff == '0);
   assign sts.w_empty   = (wq_count_ff == '0);
   assign sts.walk_done = !pend_ff && (walk_r_ff == cur_count);
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: hdl/two_level_task_run_queue_core.sv
// Two-priority task run queue: push, remove, re-queue and dispatch of task ids.
// Remove walks the selected queue's occupancy; activate walks the worker queue, then pushes.
// A new request word is stalled until the previous one has loaded its response word.
// The remove walk reads one entry per cycle through the queue memory's single read port.
// A new request word is taken while the previous response word waits.
// Reset (synchronous) empties both queues and clears the counters; no clearing pass.
module two_level_task_run_queue_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tlrq_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tlrq_pkg::rsp_word_type rsp_word
);
   import tlrq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tlrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tlrq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

// File: verif/tlrq_checker.sv
// Response checker for the two-level task run queue: predicts every response word and compares.
module tlrq_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  tlrq_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  tlrq_pkg::rsp_word_type rsp_word,
   output int                     fail_count,
   output int                     pending_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import tlrq_pkg::*;

   typedef logic [ID_W-1:0] id_list_type[$];

   id_list_type      action_ids;
   id_list_type      worker_ids;
   logic [CNT_W-1:0] action_drops;
   logic [CNT_W-1:0] worker_drops;
   logic [CNT_W-1:0] empty_dispatches;
   rsp_word_type     outcome_q[$];
   int               misses;

   // Keep the order of everything except the given id.
   function automatic id_list_type without_id(id_list_type src, logic [ID_W-1:0] id);
      id_list_type kept;
      foreach (src[i]) begin
         if (src[i] != id) kept.push_back(src[i]);
      end
      return kept;
   endfunction

   function automatic rsp_word_type schedule_outcome(req_word_type w);
      rsp_word_type r;
      r = '0;
      r.status = ST_OK;
      case (w.opcode)
         OP_PUSH_ACT: begin
            if (action_ids.size() < ACTION_DEPTH) action_ids.push_back(w.task_id);
            else begin
               action_drops++;
               r.status = ST_FULL;
            end
         end
         OP_PUSH_WRK: begin
            if (worker_ids.size() < WORKER_DEPTH) worker_ids.push_back(w.task_id);
            else begin
               worker_drops++;
               r.status = ST_FULL;
            end
         end
         OP_REM_ACT: action_ids = without_id(action_ids, w.task_id);
         OP_REM_WRK: worker_ids = without_id(worker_ids, w.task_id);
         OP_ACTIVATE: begin
            worker_ids = without_id(worker_ids, w.task_id);
            if (worker_ids.size() < WORKER_DEPTH) worker_ids.push_back(w.task_id);
            else begin
               worker_drops++;
               r.status = ST_FULL;
            end
         end
         OP_DISPATCH: begin
            if (action_ids.size() > 0) begin
               r.run_id       = action_ids.pop_front();
               r.dispatched   = 1'b1;
               r.from_actions = 1'b1;
            end else if (worker_ids.size() > 0) begin
               r.run_id     = worker_ids.pop_front();
               r.dispatched = 1'b1;
            end else begin
               empty_dispatches++;
               r.status = ST_EMPTY;
            end
         end
         default: ;
      endcase
      r.pending_total = PEND_W'(action_ids.size() + worker_ids.size());
      return r;
   endfunction

   function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (got === want) return 0;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         action_ids.delete();
         worker_ids.delete();
         outcome_q.delete();
         action_drops     = '0;
         worker_drops     = '0;
         empty_dispatches = '0;
         misses           = 0;
         fail_count    <= 0;
         pending_words <= 0;
      end else begin
         // compare before predicting: a word taken this edge cannot answer itself
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $error("response word with nothing expected: %p", rsp_word);
               misses++;
            end else begin
               want = outcome_q.pop_front();
               misses += field_differs("status", 32'(want.status), 32'(rsp_word.status));
               misses += field_differs("dispatched", 32'(want.dispatched),
                                       32'(rsp_word.dispatched));
               misses += field_differs("run_id", 32'(want.run_id), 32'(rsp_word.run_id));
               misses += field_differs("from_actions", 32'(want.from_actions),
                                       32'(rsp_word.from_actions));
               misses += field_differs("pending_total", 32'(want.pending_total),
                                       32'(rsp_word.pending_total));
            end
         end
         if (req_valid && !req_stall) outcome_q.push_back(schedule_outcome(req_word));
         fail_count    <= misses;
         pending_words <= outcome_q.size();
      end
   end

endmodule

// File: verif/testbench.sv
// Top of the task run queue testbench: request stimulus, response stalls, watchdog and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tlrq_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam int RANDOM_WORDS   = 2000;
   localparam int HOLD_AT_CYCLE  = 2500;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 40;

   typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   int           fail_count;
   int           pending_words;
   int           idle_cycles = 0;
   logic         quiet = 1'b0;

   two_level_task_run_queue_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   tlrq_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [OP_W-1:0] pick_op(mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (r < 30) return OP_PUSH_ACT;
            if (r < 62) return OP_PUSH_WRK;
            if (r < 77) return OP_ACTIVATE;
            if (r < 82) return OP_REM_ACT;
            if (r < 87) return OP_REM_WRK;
            if (r < 96) return OP_DISPATCH;
         end
         MIX_DRAIN: begin
            if (r < 10) return OP_PUSH_ACT;
            if (r < 20) return OP_PUSH_WRK;
            if (r < 25) return OP_ACTIVATE;
            if (r < 30) return OP_REM_ACT;
            if (r < 35) return OP_REM_WRK;
            if (r < 97) return OP_DISPATCH;
         end
         default: begin
            if (r < 18) return OP_PUSH_ACT;
            if (r < 36) return OP_PUSH_WRK;
            if (r < 50) return OP_ACTIVATE;
            if (r < 62) return OP_REM_ACT;
            if (r < 74) return OP_REM_WRK;
            if (r < 96) return OP_DISPATCH;
         end
      endcase
      return r[0] ? OP_SPARE_HI : OP_SPARE_LO;
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic offer_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{opcode: op, task_id: id};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      mix_type         mix;
      logic [ID_W-1:0] pool [0:23];
      int              pool_size;
      int              block_len;
      int              sent;
      logic [ID_W-1:0] id;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      offer_word(OP_DISPATCH, 16'h0000);   // underflow on empty queues
      offer_word(OP_REM_ACT, 16'h1234);    // absent ids
      offer_word(OP_REM_WRK, 16'h1234);
      offer_word(OP_SPARE_LO, 16'hFFFF);
      offer_word(OP_SPARE_HI, 16'h0000);
      offer_word(OP_PUSH_ACT, 16'h0000);
      offer_word(OP_PUSH_ACT, 16'hFFFF);
      offer_word(OP_PUSH_ACT, 16'hFFFF);
      offer_word(OP_PUSH_ACT, 16'h5A5A);
      offer_word(OP_PUSH_WRK, 16'hA5A5);
      offer_word(OP_PUSH_WRK, 16'h0001);
      offer_word(OP_PUSH_WRK, 16'hA5A5);
      offer_word(OP_ACTIVATE, 16'h0001);   // present: moves to the back
      offer_word(OP_ACTIVATE, 16'h8000);   // absent: plain push
      offer_word(OP_REM_ACT, 16'hFFFF);    // both copies go
      offer_word(OP_REM_WRK, 16'hA5A5);
      repeat (5) offer_word(OP_DISPATCH, 16'hFFFF);

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 19)) inside
            [0:7]:   mix = MIX_FILL;
            [8:12]:  mix = MIX_DRAIN;
            default: mix = MIX_BLEND;
         endcase
         quiet     = ($urandom_range(0, 4) == 0);
         pool_size = $urandom_range(3, 24);
         block_len = $urandom_range(30, 90);
         foreach (pool[i]) pool[i] = 16'($urandom);
         for (int k = 0; k < block_len; k++) begin
            if ($urandom_range(0, 99) < 85) id = pool[$urandom_range(0, pool_size - 1)];
            else id = 16'($urandom);
            offer_word(pick_op(mix), id);
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (pending_words != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_words == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Response side: random stall runs, quiet stretches, and one long hold to back the block up.
   initial begin
      int  cycle_no;
      int  stall_len;
      int  free_len;
      bit  hold_done;

      cycle_no  = 0;
      hold_done = 1'b0;
      @(negedge clock);
      forever begin
         if (!hold_done && cycle_no >= HOLD_AT_CYCLE) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            cycle_no += HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            if ($urandom_range(0, 7) == 0) begin
               stall_len = 0;
               free_len  = $urandom_range(30, 80);
            end else begin
               stall_len = pick_gap();
               free_len  = $urandom_range(1, 6);
            end
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            repeat (free_len) @(negedge clock);
            cycle_no += stall_len + free_len;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
